### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers used by the ring queue core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SMRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SMRQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/smrq_pkg.sv
// ---------------------------------------------------------------------------
// smrq_pkg
// types and constants of the slotted message ring queue
// ---------------------------------------------------------------------------
package smrq_pkg;

  localparam int unsigned MaxSlotsDef     = 16;
  localparam int unsigned MaxSlotBytesDef = 64;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // register select, taken from the word address bit
  localparam logic RegSlotCount = 1'b0;
  localparam logic RegSlotBytes = 1'b1;

  localparam logic [4:0] SlotCountRst = 5'd16;
  localparam logic [6:0] SlotBytesRst = 7'd64;

  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StTooLarge = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StEmpty    = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] request_length;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } buf_stat_t;

endpackage

### sv/slotted_message_ring_queue_core.sv
// ---------------------------------------------------------------------------
// slotted_message_ring_queue_core
// inter-core mailbox holding messages in fixed-size slots of a byte ring
// ---------------------------------------------------------------------------
// channel  dir  handshake                 word
// in       in   in_valid_i / in_ready_o   in_item_i  (one write byte or one read request)
// out      out  out_valid_o / out_ready_i out_item_o (status or read byte)
// cfg      in   psel/penable/pwrite       slot_count at 0x0, slot_bytes at 0x4
//
// a write byte is taken whenever in_ready_o is high; the final byte also pushes its status word
// a read of n bytes streams from the single store read port after a start step, one byte per
// cycle while the result buffer has room, and holds the block until its last byte is issued
// input is held off while a read streams or the result buffer is full
// stalls on out_ready_i propagate back through the two-word result buffer
// reset clears indices and write progress; the store itself is not cleared
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slotted_message_ring_queue_core import smrq_pkg::*; #(
  parameter int unsigned MAX_SLOTS      = MaxSlotsDef,
  parameter int unsigned MAX_SLOT_BYTES = MaxSlotBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned IW    = $clog2(MAX_SLOTS);
  localparam int unsigned CW    = IW + 1;
  localparam int unsigned BW    = $clog2(MAX_SLOT_BYTES + 1);
  localparam int unsigned DEPTH = MAX_SLOTS * MAX_SLOT_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = IW + BW;

  // configuration registers
  logic [4:0] slot_count_q;
  logic [6:0] slot_bytes_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCountRst;
      slot_bytes_q <= SlotBytesRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegSlotCount: slot_count_q <= pwdata[4:0];
        RegSlotBytes: slot_bytes_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegSlotCount: prdata = {{(CfgDataW-5){1'b0}}, slot_count_q};
      RegSlotBytes: prdata = {{(CfgDataW-7){1'b0}}, slot_bytes_q};
      default:      prdata = '0;
    endcase
  end

  // registers clamped to the range the hardware supports
  logic [CW-1:0] eff_cnt;
  logic [BW-1:0] eff_sb;

  always_comb begin
    if (slot_count_q < 5'd2) begin
      eff_cnt = CW'(2);
    end else if (32'(slot_count_q) > 32'(MAX_SLOTS)) begin
      eff_cnt = CW'(MAX_SLOTS);
    end else begin
      eff_cnt = CW'(slot_count_q);
    end
    if (slot_bytes_q == 7'd0) begin
      eff_sb = BW'(1);
    end else if (32'(slot_bytes_q) > 32'(MAX_SLOT_BYTES)) begin
      eff_sb = BW'(MAX_SLOT_BYTES);
    end else begin
      eff_sb = BW'(slot_bytes_q);
    end
  end

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] cnt);
    logic [CW-1:0] n;
    n = {1'b0, idx} + CW'(1);
    if (n >= cnt) begin
      next_idx = '0;
    end else begin
      next_idx = IW'(n);
    end
  endfunction

  // ring state
  logic [IW-1:0] head_q, tail_q;
  logic [BW-1:0] wr_off_q;
  logic [1:0]    wr_rej_q;

  // read streaming state
  logic          busy_q;
  logic          inflight_q;
  logic          last_tag_q;
  logic [AW-1:0] rd_addr_q;
  logic [BW-1:0] rd_cnt_q, rd_len_q;

  // result buffer
  buf_stat_t buf_stat;
  logic      push;
  out_item_t push_item;

  logic in_acc;
  assign in_ready_o = ~busy_q & ~inflight_q & (buf_stat.count != 2'd2);
  assign in_acc     = in_valid_i & in_ready_o;

  logic is_write, is_read;
  assign is_write = in_acc & (in_item_i.operation == OpWrite);
  assign is_read  = in_acc & (in_item_i.operation == OpRead);

  // write side
  logic          first_byte, too_large, ring_full;
  logic [1:0]    rej_eff;
  logic          wr_take, mem_we;
  logic [PW-1:0] wr_base;
  logic [AW-1:0] wr_addr;

  assign too_large  = in_item_i.request_length > 8'(eff_sb);
  assign ring_full  = next_idx(head_q, eff_cnt) == tail_q;
  assign first_byte = (wr_off_q == '0) && (wr_rej_q == StOk);

  always_comb begin
    rej_eff = wr_rej_q;
    if (first_byte) begin
      priority if (too_large) begin
        rej_eff = StTooLarge;
      end else if (ring_full) begin
        rej_eff = StFull;
      end
    end
  end

  assign wr_take = (rej_eff == StOk) && (wr_off_q < eff_sb);
  assign mem_we  = is_write & wr_take & (8'(wr_off_q) < in_item_i.request_length);
  assign wr_base = PW'(head_q) * PW'(eff_sb);
  assign wr_addr = AW'(wr_base) + AW'(wr_off_q);

  // read side
  logic          rd_empty, rd_zero, rd_start, rd_issue, rd_last;
  logic [PW-1:0] rd_base;

  assign rd_empty = tail_q == head_q;
  assign rd_zero  = in_item_i.request_length == 8'd0;
  assign rd_start = is_read & ~too_large & ~rd_empty & ~rd_zero;
  assign rd_base  = PW'(tail_q) * PW'(eff_sb);
  // keep buffered plus in-flight words within the two buffer places
  assign rd_issue = busy_q &&
                    (({1'b0, buf_stat.count} + {2'b0, inflight_q}) <=
                     (3'd1 + {2'b0, buf_stat.pop}));
  assign rd_last  = BW'(rd_cnt_q + BW'(1)) == rd_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      wr_off_q   <= '0;
      wr_rej_q   <= StOk;
      busy_q     <= 1'b0;
      inflight_q <= 1'b0;
      last_tag_q <= 1'b0;
      rd_addr_q  <= '0;
      rd_cnt_q   <= '0;
      rd_len_q   <= '0;
    end else begin
      inflight_q <= rd_issue;
      if (is_write) begin
        if (in_item_i.last_byte) begin
          if (rej_eff == StOk) begin
            head_q <= next_idx(head_q, eff_cnt);
          end
          wr_off_q <= '0;
          wr_rej_q <= StOk;
        end else begin
          wr_rej_q <= rej_eff;
          if (wr_take) begin
            wr_off_q <= wr_off_q + BW'(1);
          end
        end
      end
      if (is_read && !too_large && !rd_empty) begin
        tail_q <= next_idx(tail_q, eff_cnt);
      end
      if (rd_start) begin
        busy_q    <= 1'b1;
        rd_addr_q <= AW'(rd_base);
        rd_cnt_q  <= '0;
        rd_len_q  <= BW'(in_item_i.request_length);
      end else if (rd_issue) begin
        rd_addr_q  <= rd_addr_q + AW'(1);
        rd_cnt_q   <= rd_cnt_q + BW'(1);
        last_tag_q <= rd_last;
        if (rd_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // message store, one write port and one registered read port
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= in_item_i.data_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      rdata_q <= mem[rd_addr_q];
    end
  end

  // result words: store data, write status, or read error / zero-length read status
  always_comb begin
    push      = 1'b0;
    push_item = '{status: StOk, read_byte: 8'd0, byte_valid: 1'b0, last: 1'b1};
    priority if (inflight_q) begin
      push      = 1'b1;
      push_item = '{status: StOk, read_byte: rdata_q, byte_valid: 1'b1,
                    last: last_tag_q};
    end else if (is_write) begin
      push             = in_item_i.last_byte;
      push_item.status = rej_eff;
    end else if (is_read) begin
      push = ~rd_start;
      priority if (too_large) begin
        push_item.status = StTooLarge;
      end else if (rd_empty) begin
        push_item.status = StEmpty;
      end
    end
  end

  smrq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_i     (out_ready_i),
    .valid_o     (out_valid_o),
    .item_o      (out_item_o),
    .stat_o      (buf_stat)
  );

  `SMRQ_ASSERT(a_rd_cnt_bound, busy_q |-> (rd_cnt_q < rd_len_q), "read counter overran length")
  `SMRQ_ASSERT(a_rej_no_offset, (wr_rej_q != StOk) |-> (wr_off_q == '0), "rejected message advanced")
  `SMRQ_NEVER(a_buf_overflow, push && (buf_stat.count == 2'd2) && !buf_stat.pop, "result buffer overflow")
  `SMRQ_ASSERT(a_last_ends_burst, (rd_issue && rd_last) |=> !busy_q, "stream kept going after last")

endmodule

### sv/smrq_out_buf.sv
// ---------------------------------------------------------------------------
// smrq_out_buf
// two-word result buffer: output register plus skid register
// ---------------------------------------------------------------------------
module smrq_out_buf import smrq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t push_item_i,
  input  logic      ready_i,
  output logic      valid_o,
  output out_item_t item_o,
  output buf_stat_t stat_o
);

  logic      out_vld_q, out_vld_d;
  logic      skid_vld_q, skid_vld_d;
  out_item_t out_q, out_d;
  out_item_t skid_q, skid_d;
  logic      pop;

  assign pop = out_vld_q & ready_i;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        out_d = skid_q;
        if (push_i) begin
          skid_d = push_item_i;
        end else begin
          skid_vld_d = 1'b0;
        end
      end else if (push_i) begin
        out_d = push_item_i;
      end else begin
        out_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q) begin
        out_d     = push_item_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = push_item_i;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o      = out_vld_q;
  assign item_o       = out_q;
  assign stat_o.count = {1'b0, out_vld_q} + {1'b0, skid_vld_q};
  assign stat_o.pop   = pop;

endmodule

### tb/tb_slotted_message_ring_queue_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_slotted_message_ring_queue_core
// self-checking bench for the slotted message ring queue core: a scoreboard
// predicts every status and read-back byte from the words accepted on the
// input channel and matches them in order against the output channel, over
// several slot settings with random gaps, stalls and one long output hold-off
// ---------------------------------------------------------------------------
import smrq_pkg::*;

class ring_queue_scoreboard;
  logic [4:0] slot_count;
  logic [6:0] slot_bytes;
  logic [3:0] head_idx;
  logic [3:0] tail_idx;
  logic [7:0] wr_offset;
  logic [1:0] wr_reject;
  logic [7:0] store_data [1024];
  bit         store_valid [1024];
  out_item_t  due_words [$];
  int         errors;

  function new();
    slot_count = SlotCountRst;
    slot_bytes = SlotBytesRst;
    head_idx   = '0;
    tail_idx   = '0;
    wr_offset  = '0;
    wr_reject  = StOk;
    errors     = 0;
    foreach (store_valid[a]) store_valid[a] = 1'b0;
  endfunction

  function int ring_slots();
    int c;
    c = slot_count;
    if (c < 2) c = 2;
    if (c > int'(MaxSlotsDef)) c = MaxSlotsDef;
    return c;
  endfunction

  function int slot_size();
    int b;
    b = slot_bytes;
    if (b < 1) b = 1;
    if (b > int'(MaxSlotBytesDef)) b = MaxSlotBytesDef;
    return b;
  endfunction

  // an index left above the ring by a reconfiguration also wraps to zero
  function logic [3:0] next_slot(logic [3:0] idx);
    int n;
    n = int'(idx) + 1;
    if (n >= ring_slots()) n = 0;
    return n[3:0];
  endfunction

  function void set_register(logic sel, logic [CfgDataW-1:0] value);
    if (sel == RegSlotCount) slot_count = value[4:0];
    else slot_bytes = value[6:0];
  endfunction

  // bytes of the tail slot that hold written data, counted from the start
  function int written_prefix();
    int sz;
    int n;
    sz = slot_size();
    n  = 0;
    while (n < sz && store_valid[int'(tail_idx) * sz + n]) n++;
    return n;
  endfunction

  function void take_request(in_item_t it);
    int        sz;
    int        addr;
    out_item_t w;
    sz = slot_size();
    w  = '0;
    w.last = 1'b1;
    if (it.operation == OpWrite) begin
      // only the first byte of a message is checked
      if (wr_offset == 0 && wr_reject == StOk) begin
        if (int'(it.request_length) > sz) wr_reject = StTooLarge;
        else if (next_slot(head_idx) == tail_idx) wr_reject = StFull;
      end
      if (wr_reject == StOk && int'(wr_offset) < sz) begin
        if (wr_offset < it.request_length) begin
          addr = int'(head_idx) * sz + int'(wr_offset);
          store_data[addr]  = it.data_byte;
          store_valid[addr] = 1'b1;
        end
        wr_offset++;
      end
      if (it.last_byte) begin
        w.status = wr_reject;
        if (wr_reject == StOk) head_idx = next_slot(head_idx);
        wr_offset = '0;
        wr_reject = StOk;
        due_words.push_back(w);
      end
    end else if (int'(it.request_length) > sz) begin
      w.status = StTooLarge;
      due_words.push_back(w);
    end else if (tail_idx == head_idx) begin
      w.status = StEmpty;
      due_words.push_back(w);
    end else if (it.request_length == 0) begin
      w.status = StOk;
      tail_idx = next_slot(tail_idx);
      due_words.push_back(w);
    end else begin
      for (int b = 0; b < int'(it.request_length); b++) begin
        addr = int'(tail_idx) * sz + b;
        w.status     = StOk;
        w.read_byte  = store_data[addr];
        w.byte_valid = 1'b1;
        w.last       = (b + 1 == int'(it.request_length));
        due_words.push_back(w);
      end
      tail_idx = next_slot(tail_idx);
    end
  endfunction

  function void check_word(out_item_t got);
    out_item_t w;
    if (due_words.size() == 0) begin
      $error("unexpected word: status %0d read_byte %02h byte_valid %0d last %0d",
             got.status, got.read_byte, got.byte_valid, got.last);
      errors++;
      return;
    end
    w = due_words.pop_front();
    if (got.status !== w.status) begin
      $error("status: expected %0d, got %0d", w.status, got.status);
      errors++;
    end
    if (got.read_byte !== w.read_byte) begin
      $error("read_byte: expected %02h, got %02h", w.read_byte, got.read_byte);
      errors++;
    end
    if (got.byte_valid !== w.byte_valid) begin
      $error("byte_valid: expected %0d, got %0d", w.byte_valid, got.byte_valid);
      errors++;
    end
    if (got.last !== w.last) begin
      $error("last: expected %0d, got %0d", w.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_slotted_message_ring_queue_core;

  localparam int CycleLimit = 500_000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_item_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  ring_queue_scoreboard sb_h = new();

  int reg_errors    = 0;
  int cycle_count   = 0;
  int hold_requests = 0;
  int burst_left    = 0;
  bit gaps_off      = 1'b0;
  int msg_left      = 0;
  int msg_len       = 0;

  slotted_message_ring_queue_core i_dut (.*);

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb_h.check_word(out_item_o);
  end

  // receiver: changing stall pattern, plus a long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    int holds_seen;
    mode_left   = 0;
    hold_left   = 0;
    holds_seen  = 0;
    mode        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("run did not finish within %0d cycles", CycleLimit);
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_item_t make_word(logic op, int len, int data, logic fin);
    in_item_t it;
    it.operation      = op;
    it.request_length = len[7:0];
    it.data_byte      = data[7:0];
    it.last_byte      = fin;
    return it;
  endfunction

  function automatic int next_gap();
    if (gaps_off) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 12);
    return $urandom_range(1, 6);
  endfunction

  // read lengths never reach a stored byte that was not written
  function automatic logic [7:0] read_length(int sz);
    int avail;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(sz + 1, 255));
    if (sb_h.head_idx == sb_h.tail_idx) return 8'($urandom_range(0, sz));
    avail = sb_h.written_prefix();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, avail));
    return 8'(avail);
  endfunction

  function automatic in_item_t random_word();
    in_item_t it;
    int       sz;
    int       pick;
    int       kind;
    sz   = sb_h.slot_size();
    pick = $urandom_range(0, 99);
    it   = '0;
    if (pick < 6) begin
      it = $bits(in_item_t)'($urandom);
      if (it.operation == OpRead) it.request_length = read_length(sz);
    end else if (msg_left == 0 && pick < 50) begin
      it.operation      = OpRead;
      it.request_length = read_length(sz);
    end else begin
      // a fresh message, now and then breaking off the one in flight
      if (msg_left == 0 || pick >= 97) begin
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
          msg_len  = $urandom_range(sz + 1, 255);
          msg_left = $urandom_range(1, 3);
        end else begin
          if (kind < 15) msg_len = $urandom_range(0, sz);
          else msg_len = $urandom_range(1, (sz < 6) ? sz : 6);
          msg_left = (msg_len == 0) ? 1 : msg_len;
          if (kind >= 90) msg_left += $urandom_range(1, 2);
        end
      end
      msg_left--;
      it.operation      = OpWrite;
      it.request_length = msg_len[7:0];
      it.data_byte      = 8'($urandom);
      it.last_byte      = (msg_left == 0);
    end
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input in_item_t it, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb_h.take_request(it);
    @(negedge clk_i);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_word(random_word(), next_gap());
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb_h.due_words.size() != 0) @(negedge clk_i);
    // a trailing write byte gives no word, so allow it to settle
    repeat (12) @(negedge clk_i);
  endtask

  // close any open message and empty the ring with zero-length reads,
  // so fixed reads after a slot change only meet freshly written bytes
  task automatic settle_ring();
    if (sb_h.wr_offset != 0 || sb_h.wr_reject != StOk) begin
      send_word(make_word(OpWrite, 0, 0, 1'b1), 0);
    end
    while (sb_h.head_idx != sb_h.tail_idx) begin
      send_word(make_word(OpRead, 0, 0, 1'b0), 0);
    end
    msg_left = 0;
    drain();
  endtask

  task automatic write_register(input logic sel, input logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] readback;
    logic [CfgDataW-1:0] mask;
    mask    = (sel == RegSlotCount) ? 32'h1f : 32'h7f;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb_h.set_register(sel, value);
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((readback & mask) !== (value & mask)) begin
      $error("register %0d readback: expected %0h, got %0h", sel, value & mask,
             readback & mask);
      reg_errors++;
    end
  endtask

  initial begin
    in_item_t plan [$];
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: 16 slots of 64 bytes
    plan.push_back(make_word(OpRead, 0, 0, 1'b0));       // empty ring
    plan.push_back(make_word(OpRead, 255, 0, 1'b0));     // too large
    plan.push_back(make_word(OpRead, 65, 0, 1'b1));
    plan.push_back(make_word(OpWrite, 3, 8'h00, 1'b0));
    plan.push_back(make_word(OpWrite, 3, 8'hff, 1'b0));
    plan.push_back(make_word(OpWrite, 3, 8'ha5, 1'b1));
    plan.push_back(make_word(OpWrite, 255, 8'h5a, 1'b0)); // rejected message
    plan.push_back(make_word(OpWrite, 255, 8'h66, 1'b1));
    plan.push_back(make_word(OpWrite, 0, 8'h99, 1'b1));   // zero-length message
    plan.push_back(make_word(OpWrite, 1, 8'h3c, 1'b0));   // surplus bytes dropped
    plan.push_back(make_word(OpWrite, 1, 8'hc3, 1'b0));
    plan.push_back(make_word(OpWrite, 1, 8'h7e, 1'b1));
    plan.push_back(make_word(OpRead, 3, 8'hff, 1'b0));
    plan.push_back(make_word(OpRead, 0, 0, 1'b0));        // ok with no data
    plan.push_back(make_word(OpRead, 1, 0, 1'b0));
    plan.push_back(make_word(OpRead, 1, 0, 1'b0));
    foreach (plan[k]) send_word(plan[k], next_gap());
    send_random(20);
    drain();
    settle_ring();

    // two slots of one byte; a head index left above the ring wraps
    write_register(RegSlotCount, 32'd2);
    write_register(RegSlotBytes, 32'd1);
    plan.delete();
    plan.push_back(make_word(OpWrite, 1, 8'h81, 1'b1));
    plan.push_back(make_word(OpRead, 1, 0, 1'b0));
    plan.push_back(make_word(OpWrite, 2, 8'h11, 1'b1));
    plan.push_back(make_word(OpWrite, 1, 8'h42, 1'b1));
    plan.push_back(make_word(OpWrite, 1, 8'h24, 1'b1));   // ring full
    plan.push_back(make_word(OpRead, 1, 0, 1'b0));
    plan.push_back(make_word(OpRead, 2, 0, 1'b0));
    foreach (plan[k]) send_word(plan[k], next_gap());
    send_random(18);
    drain();

    // out of range below, used as the smallest ring
    write_register(RegSlotCount, 32'd0);
    write_register(RegSlotBytes, 32'd0);
    send_random(15);
    drain();

    // out of range above, with the output held off while words keep coming
    write_register(RegSlotCount, 32'd31);
    write_register(RegSlotBytes, 32'd127);
    gaps_off = 1'b1;
    hold_requests++;
    send_random(26);
    gaps_off = 1'b0;
    drain();

    write_register(RegSlotCount, $urandom_range(2, 16));
    write_register(RegSlotBytes, $urandom_range(1, 64));
    send_random(24);
    drain();
    repeat (8) @(negedge clk_i);

    if (sb_h.errors == 0 && reg_errors == 0 && sb_h.due_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
